// ----- rtl/core/random_pick_page_allocator_defines.svh -----
// assertion macros for the page allocator
// no dependencies
`ifndef RANDOM_PICK_PAGE_ALLOCATOR_DEFINES_SVH
`define RANDOM_PICK_PAGE_ALLOCATOR_DEFINES_SVH
// implication checked on every edge outside reset
`define RPPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rppa check failed");
// next-cycle implication
`define RPPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rppa check failed");
`endif

// ----- rtl/core/rppa_pkg.sv -----
// shared types and constants for the page allocator
// no dependencies
package rppa_pkg;
    localparam int PAGE_SLOTS_DEF = 1024;
    localparam int MAX_DUMP_DEF   = 64;
    localparam int PN_W           = 20;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_DUMP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_DUMP  = 2'd3;

    localparam logic REG_LOWEST = 1'b0;
    localparam logic REG_TOP    = 1'b1;

    // classified work item handed from front to back
    typedef struct packed {
        cmd_t            cmd;
        logic            bad;
        logic [PN_W-1:0] pn;
        logic [30:0]     rnd;
        logic [6:0]      cnt;
    } op_t;
endpackage

// ----- rtl/core/random_pick_page_allocator.sv -----
// top level of the random-pick page allocator
// depends on rppa_pkg, rppa_front, rppa_back and the defines header
//
// channel  dir  handshake          fields
// s_       in   s_valid/s_ready    command address random_value count
// m_       out  m_valid/m_ready    page_address status last
// cfg_     in   cfg_valid/ready    cfg_index cfg_data
//
// a word is registered in the front queue before the back end takes it
// allocate: the bit-serial modulo, then S_RD, S_ARD and S_PICK locate and read
// the picked entry, then each entry between it and the head moves down a place (up to
// PAGE_SLOTS), then the result state; free: allocated-list scan and shift, then
// the result state; dump: a read state and an output state per word. reset is
// synchronous, active low, lists start empty. a stalled result register holds
// the back end only; the front fills its two-entry queue
`include "random_pick_page_allocator_defines.svh"
module random_pick_page_allocator #(
    parameter int PAGE_SLOTS = rppa_pkg::PAGE_SLOTS_DEF,
    parameter int MAX_DUMP   = rppa_pkg::MAX_DUMP_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_address,
    input  logic [30:0] s_random_value,
    input  logic [6:0]  s_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_page_address,
    output logic [1:0]  m_status,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [20:0] cfg_data
);
    // configuration registers
    logic [19:0] lowest_reg;
    logic [20:0] top_reg;
    logic        q_valid, q_ready;
    rppa_pkg::op_t q_op;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_reg <= '0;
            top_reg    <= 21'h100000;
        end else if (cfg_valid) begin
            if (cfg_index == rppa_pkg::REG_LOWEST) lowest_reg <= cfg_data[19:0];
            else top_reg <= cfg_data;
        end
    end

    rppa_front #(.MAX_DUMP(MAX_DUMP)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_address,
        .s_random_value, .s_count, .lowest_page(lowest_reg), .top_page(top_reg),
        .q_valid, .q_ready, .q_op
    );

    rppa_back #(.PAGE_SLOTS(PAGE_SLOTS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_op,
        .m_valid, .m_ready, .m_page_address, .m_status, .m_last
    );

    // error results never carry an address
    `RPPA_ASSERT_IMP(a_err_zero, m_valid && m_status != rppa_pkg::ST_OK, m_page_address == 32'd0)
    // a result waiting on the sink holds
    `RPPA_ASSERT_NXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_page_address))
endmodule

// ----- rtl/core/rppa_front.sv -----
// front end: accepts words, checks free addresses, queues classified ops
// depends on rppa_pkg
module rppa_front #(
    parameter int MAX_DUMP = rppa_pkg::MAX_DUMP_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_command,
    input  logic [31:0]            s_address,
    input  logic [30:0]            s_random_value,
    input  logic [6:0]             s_count,
    input  logic [19:0]            lowest_page,
    input  logic [20:0]            top_page,
    output logic                   q_valid,
    input  logic                   q_ready,
    output rppa_pkg::op_t          q_op
);
    // two-entry queue
    rppa_pkg::op_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    rppa_pkg::op_t op_in;
    logic [19:0] pn;
    logic push, pop;

    assign pn = s_address[31:12];
    always_comb begin
        op_in.cmd = rppa_pkg::cmd_t'(s_command);
        op_in.bad = (s_address[11:0] != 12'd0) || (pn < lowest_page)
                    || ({1'b0, pn} >= top_page);
        op_in.pn  = pn;
        op_in.rnd = s_random_value;
        op_in.cnt = (s_count > 7'(MAX_DUMP)) ? 7'(MAX_DUMP) : s_count;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready && (s_command != rppa_pkg::CMD_NONE);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = q_reg[rd_reg];
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
            if (pop) rd_reg <= ~rd_reg;
        end
        // write slot sits just past the stored entries
        if (push) q_reg[rd_reg ^ cnt_reg[0]] <= op_in;
    end
endmodule

// ----- rtl/core/rppa_back.sv -----
// back end: list storage, modulo unit, order-preserving shifts, result register
// depends on rppa_pkg
module rppa_back #(
    parameter int PAGE_SLOTS = rppa_pkg::PAGE_SLOTS_DEF,
    parameter int IW = $clog2(PAGE_SLOTS),
    parameter int TW = $clog2(PAGE_SLOTS + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  rppa_pkg::op_t  q_op,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [31:0]    m_page_address,
    output logic [1:0]     m_status,
    output logic           m_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_RD, S_ARD, S_PICK, S_SHIFT, S_SCAN, S_ASHIFT, S_DRD, S_DOUT,
        S_OUT
    } state_t;

    logic [19:0] free_mem  [PAGE_SLOTS];
    logic [19:0] alloc_mem [PAGE_SLOTS];

    state_t       st_reg;
    rppa_pkg::op_t op_reg;
    logic [TW-1:0] ftot_reg, atot_reg;
    logic [TW-1:0] i_reg;
    logic [31:0]  rem_reg;
    logic [4:0]   bit_reg;
    logic [19:0]  frd_reg, ard_reg;
    logic [6:0]   dn_reg;
    logic         out_v_reg, out_last_reg;
    logic [31:0]  out_a_reg;
    logic [1:0]   out_s_reg;
    logic         fwe, awe;
    logic [IW-1:0] fwa, awa, fra, ara;
    logic [19:0]  fwd, awd;
    logic [31:0]  rem_sh;
    logic         out_load, out_free;
    logic         alloc_fail, free_fail, dump_big, dump_none;

    assign q_ready        = (st_reg == S_IDLE) && !out_v_reg;
    assign m_valid        = out_v_reg;
    assign m_page_address = out_a_reg;
    assign m_status       = out_s_reg;
    assign m_last         = out_last_reg;
    assign rem_sh         = {rem_reg[30:0], op_reg.rnd[bit_reg]};

    // result register can take a new word
    assign out_free   = !out_v_reg || m_ready;
    assign alloc_fail = (ftot_reg == '0) || (atot_reg == TW'(PAGE_SLOTS));
    assign free_fail  = q_op.bad || (ftot_reg == TW'(PAGE_SLOTS));
    assign dump_big   = 32'(q_op.cnt) > 32'(atot_reg);
    assign dump_none  = (q_op.cnt == 7'd0);

    // memory ports and result load
    always_comb begin
        fwe = 1'b0; fwa = ftot_reg[IW-1:0]; fwd = op_reg.pn;
        awe = 1'b0; awa = atot_reg[IW-1:0]; awd = frd_reg;
        fra = i_reg[IW-1:0]; ara = i_reg[IW-1:0];
        out_load = 1'b0;
        case (st_reg)
            S_IDLE: begin
                // prime the first allocated-list entry for a scan
                ara = '0;
                if (q_valid && q_ready) begin
                    case (q_op.cmd)
                        rppa_pkg::CMD_ALLOC: out_load = alloc_fail;
                        rppa_pkg::CMD_FREE:  out_load = free_fail;
                        rppa_pkg::CMD_DUMP:  out_load = dump_big || dump_none;
                        default: ;
                    endcase
                end
            end
            // picked page goes to the tail of the allocated list
            S_PICK: begin
                awe = 1'b1;
                fra = IW'(i_reg + 1'b1);
            end
            // frd_reg holds entry i+1 here
            S_SHIFT: begin
                if (i_reg + 1'b1 < ftot_reg) begin
                    fwe = 1'b1; fwa = i_reg[IW-1:0]; fwd = frd_reg;
                end
                fra = IW'(i_reg + 2'd2);
            end
            // freed page pushed at the head on the first scan cycle
            S_SCAN: begin
                fwe = (i_reg == '0);
                ara = IW'(i_reg + 1'b1);
            end
            // ard_reg holds entry i+1 here
            S_ASHIFT: begin
                if (i_reg + 1'b1 < atot_reg) begin
                    awe = 1'b1; awa = i_reg[IW-1:0]; awd = ard_reg;
                end
                ara = IW'(i_reg + 2'd2);
            end
            S_DOUT: out_load = out_free;
            S_OUT:  out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fwe) free_mem[fwa] <= fwd;
        if (awe) alloc_mem[awa] <= awd;
        frd_reg <= free_mem[fra];
        ard_reg <= alloc_mem[ara];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            ftot_reg  <= '0;
            atot_reg  <= '0;
            out_v_reg <= 1'b0;
        end else begin
            if (out_load) out_v_reg <= 1'b1;
            else if (m_ready) out_v_reg <= 1'b0;
            case (st_reg)
                S_IDLE: if (q_valid && q_ready) begin
                    op_reg       <= q_op;
                    out_a_reg    <= '0;
                    out_last_reg <= 1'b1;
                    case (q_op.cmd)
                        rppa_pkg::CMD_ALLOC: begin
                            out_s_reg <= alloc_fail ? rppa_pkg::ST_EMPTY : rppa_pkg::ST_OK;
                            if (!alloc_fail) begin
                                rem_reg <= '0; bit_reg <= 5'd30; st_reg <= S_MOD;
                            end
                        end
                        rppa_pkg::CMD_FREE: begin
                            out_s_reg <= free_fail ? rppa_pkg::ST_BAD : rppa_pkg::ST_OK;
                            if (!free_fail) begin
                                i_reg <= '0; st_reg <= S_SCAN;
                            end
                        end
                        rppa_pkg::CMD_DUMP: begin
                            out_s_reg <= dump_big ? rppa_pkg::ST_DUMP : rppa_pkg::ST_OK;
                            if (!dump_big && !dump_none) begin
                                i_reg <= atot_reg - 1'b1; dn_reg <= q_op.cnt;
                                st_reg <= S_DRD;
                            end
                        end
                        default: out_s_reg <= rppa_pkg::ST_OK;
                    endcase
                end
                // restoring remainder, one bit per cycle
                S_MOD: begin
                    rem_reg <= (rem_sh >= 32'(ftot_reg)) ? rem_sh - 32'(ftot_reg) : rem_sh;
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0) begin
                        st_reg <= S_RD;
                    end
                end
                S_RD: begin
                    i_reg  <= ftot_reg - 1'b1 - TW'(rem_reg);
                    st_reg <= S_ARD;
                end
                S_ARD: st_reg <= S_PICK;
                S_PICK: begin
                    out_a_reg <= {frd_reg, 12'd0};
                    atot_reg  <= atot_reg + 1'b1;
                    st_reg    <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (i_reg + 1'b1 >= ftot_reg) begin
                        ftot_reg <= ftot_reg - 1'b1;
                        st_reg   <= S_OUT;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (i_reg >= atot_reg) begin
                        st_reg <= S_OUT;
                    end else if (ard_reg == op_reg.pn) begin
                        st_reg <= S_ASHIFT;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                    if (i_reg == '0) ftot_reg <= ftot_reg + 1'b1;
                end
                S_ASHIFT: begin
                    if (i_reg + 1'b1 >= atot_reg) begin
                        atot_reg <= atot_reg - 1'b1;
                        st_reg   <= S_OUT;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_DRD: st_reg <= S_DOUT;
                S_DOUT: if (out_free) begin
                    out_a_reg    <= {ard_reg, 12'd0};
                    out_last_reg <= (dn_reg == 7'd1);
                    dn_reg       <= dn_reg - 7'd1;
                    i_reg        <= i_reg - 1'b1;
                    st_reg       <= (dn_reg == 7'd1) ? S_IDLE : S_DRD;
                end
                S_OUT: if (out_free) begin
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
